FILE: rtl/bps_patch_apply_engine_assert.svh
// assertion macros for the bps patch apply engine checker
`ifndef BPS_PATCH_APPLY_ENGINE_ASSERT_SVH
`define BPS_PATCH_APPLY_ENGINE_ASSERT_SVH

// property checked on every clock edge outside reset
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// shared types, codes and helper functions of the bps patch apply engine
package bpa_pkg;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned TRAILER_LEN = 12;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PATCH = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_WORKING    = 3'd0,
    ST_DONE_OK    = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_SIZE_ERR   = 3'd3,
    ST_CRC_ERR    = 3'd4,
    ST_BOUNDS_ERR = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_LENGTH = 1'd0,
    REG_PATCH_LENGTH  = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    status_e     status;
    logic [16:0] target_length;
  } out_word_t;

  typedef struct packed {
    logic        busy;
    status_e     status;
    logic [16:0] target_length;
  } dec_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = 8'h42;
      2'd1: m = 8'h50;
      2'd2: m = 8'h53;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/bpa_source_mem.sv
// source memory with running crc over loaded bytes
module bpa_source_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_en_i,
  input  logic [15:0]   load_addr_i,
  input  logic [7:0]    load_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  output logic [31:0]   crc_o
);
  import bpa_pkg::*;

  logic [7:0]  mem [DEPTH];
  logic [31:0] crc_q, crc_d;
  logic        in_range;

  assign in_range = 32'(load_addr_i) < 32'(DEPTH);
  assign crc_d    = load_en_i ? crc_byte(crc_q, load_data_i) : crc_q;
  assign crc_o    = crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '1;
    end else begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i && in_range) begin
      mem[AW'(load_addr_i)] <= load_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: rtl/bpa_target_mem.sv
// target memory with write-to-read forwarding
module bpa_target_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);
  import bpa_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q, fwd_d;

  assign fwd_d     = rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i);
  assign rd_data_o = fwd_q ? fwd_data_q : mem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q      <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

endmodule

FILE: rtl/bpa_decoder.sv
// patch byte decoder with copy sequencer
module bpa_decoder #(
  parameter int unsigned SOURCE_DEPTH = 65536,
  parameter int unsigned TARGET_DEPTH = 65536,
  parameter int unsigned SAW          = 16,
  parameter int unsigned TAW          = 16,
  parameter int unsigned PW           = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pb_en_i,
  input  logic [7:0]        pb_byte_i,
  input  logic [16:0]       source_length_i,
  input  logic [23:0]       patch_length_i,
  input  logic [31:0]       source_crc_i,
  output logic              src_rd_en_o,
  output logic [SAW-1:0]    src_rd_addr_o,
  input  logic [7:0]        src_rd_data_i,
  output logic              tgt_wr_en_o,
  output logic [TAW-1:0]    tgt_wr_addr_o,
  output logic [7:0]        tgt_wr_data_o,
  output logic              tgt_rd_en_o,
  output logic [TAW-1:0]    tgt_rd_addr_o,
  input  logic [7:0]        tgt_rd_data_i,
  output logic [PW-1:0]     out_pos_o,
  output bpa_pkg::dec_stat_t stat_o
);
  import bpa_pkg::*;

  localparam int unsigned CAW = (SAW > TAW) ? SAW : TAW;

  localparam logic [3:0] PH_H0      = 4'd0;
  localparam logic [3:0] PH_H3      = 4'd3;
  localparam logic [3:0] PH_SRCSIZE = 4'd4;
  localparam logic [3:0] PH_TGTSIZE = 4'd5;
  localparam logic [3:0] PH_METALEN = 4'd6;
  localparam logic [3:0] PH_METASKP = 4'd7;
  localparam logic [3:0] PH_CMD     = 4'd8;
  localparam logic [3:0] PH_TGTDATA = 4'd9;
  localparam logic [3:0] PH_OFFSET  = 4'd10;
  localparam logic [3:0] PH_TRAILER = 4'd11;
  localparam logic [3:0] PH_STOP    = 4'd12;

  logic [3:0]     phase_q, phase_d, eff;
  logic [31:0]    vval_q, vval_d;
  logic [5:0]     vshift_q, vshift_d;
  logic [23:0]    ppos_q, ppos_d;
  logic [PW-1:0]  opos_q, opos_d;
  logic [SAW:0]   scp_q, scp_d;
  logic [PW-1:0]  tcp_q, tcp_d;
  logic [31:0]    run_q, run_d;
  logic [1:0]     kind_q, kind_d;
  logic [PW-1:0]  tsize_q, tsize_d;
  logic [31:0]    trail_q, trail_d;
  status_e        status_q, status_d;
  logic [PW-1:0]  cnt_q, cnt_d;
  logic [CAW-1:0] caddr_q, caddr_d;
  logic           csrc_q, csrc_d;
  logic           wpend_q, wpend_d;
  logic           wsrc_q, wsrc_d;

  logic [43:0] vterm, vsum;
  logic [31:0] vres;
  logic [32:0] clen, cend, slim;
  logic [33:0] base, np, npend;
  logic [23:0] start, off;
  logic        running, dwr;
  logic [7:0]  b;

  assign b       = pb_byte_i;
  assign running = cnt_q != '0;
  assign vterm   = 44'(b ^ 8'h80) << vshift_q;
  assign vsum    = 44'(vval_q) + vterm;
  assign vres    = (|vsum[43:32]) ? '1 : vsum[31:0];
  assign slim    = (33'(source_length_i) < 33'(SOURCE_DEPTH)) ? 33'(source_length_i)
                                                             : 33'(SOURCE_DEPTH);
  assign clen    = 33'(vres[31:2]) + 33'd1;
  assign cend    = 33'(opos_q) + clen;
  assign base    = (kind_q == 2'd2) ? 34'(scp_q) : 34'(tcp_q);
  assign np      = vres[0] ? (base - 34'(vres[31:1])) : (base + 34'(vres[31:1]));
  assign npend   = np + 34'(run_q);
  assign start   = patch_length_i - 24'(TRAILER_LEN);
  assign off     = ppos_q - start;

  always_comb begin
    phase_d  = phase_q;
    vval_d   = vval_q;
    vshift_d = vshift_q;
    ppos_d   = ppos_q;
    opos_d   = opos_q;
    scp_d    = scp_q;
    tcp_d    = tcp_q;
    run_d    = run_q;
    kind_d   = kind_q;
    tsize_d  = tsize_q;
    trail_d  = trail_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    caddr_d  = caddr_q;
    csrc_d   = csrc_q;
    wsrc_d   = csrc_q;
    wpend_d  = running;
    dwr      = 1'b0;
    eff      = phase_q;
    if (running) begin
      cnt_d   = cnt_q - PW'(1);
      caddr_d = caddr_q + CAW'(1);
    end
    if (wpend_q) begin
      opos_d = opos_q + PW'(1);
    end
    if (pb_en_i && status_q == ST_WORKING) begin
      ppos_d = ppos_q + 24'd1;
      if (patch_length_i < 24'(TRAILER_LEN)) begin
        status_d = ST_BOUNDS_ERR;
        phase_d  = PH_STOP;
      end else begin
        if (ppos_q >= start && phase_q == PH_CMD && vshift_q == '0) begin
          eff = PH_TRAILER;
        end
        phase_d = eff;
        if (ppos_q >= start && eff != PH_TRAILER) begin
          status_d = ST_BOUNDS_ERR;
          phase_d  = PH_STOP;
        end else begin
          if (eff == PH_SRCSIZE || eff == PH_TGTSIZE || eff == PH_METALEN ||
              eff == PH_CMD || eff == PH_OFFSET) begin
            if (b[7]) begin
              vval_d   = '0;
              vshift_d = '0;
            end else begin
              vval_d = vres;
              if (vshift_q <= 6'd28) begin
                vshift_d = vshift_q + 6'd7;
              end
            end
          end
          case (eff)
            PH_SRCSIZE: begin
              if (b[7]) begin
                if (vres != 32'(source_length_i)) begin
                  status_d = ST_SIZE_ERR;
                  phase_d  = PH_STOP;
                end else begin
                  phase_d = PH_TGTSIZE;
                end
              end
            end
            PH_TGTSIZE: begin
              if (b[7]) begin
                if (33'(vres) > 33'(TARGET_DEPTH)) begin
                  status_d = ST_BOUNDS_ERR;
                  phase_d  = PH_STOP;
                end else begin
                  tsize_d = PW'(vres);
                  phase_d = PH_METALEN;
                end
              end
            end
            PH_METALEN: begin
              if (b[7]) begin
                run_d   = vres;
                phase_d = (vres == '0) ? PH_CMD : PH_METASKP;
              end
            end
            PH_METASKP: begin
              run_d = run_q - 32'd1;
              if (run_q == 32'd1) begin
                phase_d = PH_CMD;
              end
            end
            PH_CMD: begin
              if (b[7]) begin
                if (cend > 33'(tsize_q)) begin
                  status_d = ST_BOUNDS_ERR;
                  phase_d  = PH_STOP;
                end else begin
                  kind_d = vres[1:0];
                  if (vres[1:0] == 2'd0) begin
                    if (cend > slim) begin
                      status_d = ST_BOUNDS_ERR;
                      phase_d  = PH_STOP;
                    end else begin
                      cnt_d   = clen[PW-1:0];
                      caddr_d = CAW'(opos_q);
                      csrc_d  = 1'b1;
                    end
                  end else begin
                    run_d   = 32'(clen);
                    phase_d = (vres[1:0] == 2'd1) ? PH_TGTDATA : PH_OFFSET;
                  end
                end
              end
            end
            PH_TGTDATA: begin
              dwr    = 1'b1;
              opos_d = opos_q + PW'(1);
              run_d  = run_q - 32'd1;
              if (run_q == 32'd1) begin
                phase_d = PH_CMD;
              end
            end
            PH_OFFSET: begin
              if (b[7]) begin
                phase_d = PH_CMD;
                if (kind_q == 2'd2) begin
                  if (np[33] || npend > 34'(slim)) begin
                    status_d = ST_BOUNDS_ERR;
                    phase_d  = PH_STOP;
                  end else begin
                    cnt_d   = run_q[PW-1:0];
                    caddr_d = np[CAW-1:0];
                    csrc_d  = 1'b1;
                    scp_d   = npend[SAW:0];
                    run_d   = '0;
                  end
                end else begin
                  if (np[33] || np >= 34'(opos_q)) begin
                    status_d = ST_BOUNDS_ERR;
                    phase_d  = PH_STOP;
                  end else begin
                    cnt_d   = run_q[PW-1:0];
                    caddr_d = np[CAW-1:0];
                    csrc_d  = 1'b0;
                    tcp_d   = npend[PW-1:0];
                    run_d   = '0;
                  end
                end
              end
            end
            PH_TRAILER: begin
              if (off < 24'd4) begin
                trail_d = trail_q | (32'(b) << {off[1:0], 3'b000});
              end
              if (ppos_q == patch_length_i - 24'd1) begin
                status_d = (trail_d == ~source_crc_i) ? ST_DONE_OK : ST_CRC_ERR;
                phase_d  = PH_STOP;
              end
            end
            default: begin
              if (eff <= PH_H3) begin
                if (b != magic_byte(eff[1:0])) begin
                  status_d = ST_BAD_HEADER;
                  phase_d  = PH_STOP;
                end else begin
                  phase_d = eff + 4'd1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_H0;
      vval_q   <= '0;
      vshift_q <= '0;
      ppos_q   <= '0;
      opos_q   <= '0;
      scp_q    <= '0;
      tcp_q    <= '0;
      run_q    <= '0;
      kind_q   <= '0;
      tsize_q  <= '0;
      trail_q  <= '0;
      status_q <= ST_WORKING;
      cnt_q    <= '0;
      caddr_q  <= '0;
      csrc_q   <= 1'b0;
      wpend_q  <= 1'b0;
      wsrc_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      vval_q   <= vval_d;
      vshift_q <= vshift_d;
      ppos_q   <= ppos_d;
      opos_q   <= opos_d;
      scp_q    <= scp_d;
      tcp_q    <= tcp_d;
      run_q    <= run_d;
      kind_q   <= kind_d;
      tsize_q  <= tsize_d;
      trail_q  <= trail_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      caddr_q  <= caddr_d;
      csrc_q   <= csrc_d;
      wpend_q  <= wpend_d;
      wsrc_q   <= wsrc_d;
    end
  end

  assign src_rd_en_o   = running && csrc_q;
  assign src_rd_addr_o = caddr_q[SAW-1:0];
  assign tgt_rd_en_o   = running && !csrc_q;
  assign tgt_rd_addr_o = caddr_q[TAW-1:0];
  assign tgt_wr_en_o   = wpend_q || dwr;
  assign tgt_wr_addr_o = opos_q[TAW-1:0];
  assign tgt_wr_data_o = dwr ? b : (wsrc_q ? src_rd_data_i : tgt_rd_data_i);
  assign out_pos_o     = opos_q;

  assign stat_o.busy          = running || wpend_q;
  assign stat_o.status        = status_d;
  assign stat_o.target_length = 17'(tsize_d);

endmodule

FILE: rtl/bps_patch_apply_engine.sv
// top level of the bps patch apply engine
//
//   port group   direction  handshake              content
//   cfg_*        in         cfg_valid_i/cfg_ready_o register index and data
//   in_*         in         in_valid_i/in_ready_o   func, address, data byte
//   out_*        out        out_valid_o/out_ready_i read byte, status, target length
//
// load, patch and unused words write their result word when taken, a target read
// first passes the read state while the target memory read register is loaded
// a copy of n bytes moves one byte per cycle through the source or target
// memory read port, and no word is taken until its last byte is written
// a word is taken only while the output register is empty or empties at that edge
// reset clears control state only, memories hold nothing meaningful until written
module bps_patch_apply_engine #(
  parameter int unsigned SOURCE_DEPTH = 65536,
  parameter int unsigned TARGET_DEPTH = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bpa_pkg::in_word_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bpa_pkg::out_word_t                  out_data_o
);
  import bpa_pkg::*;

  localparam int unsigned SAW = $clog2(SOURCE_DEPTH);
  localparam int unsigned TAW = $clog2(TARGET_DEPTH);
  localparam int unsigned PW  = TAW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_q, state_d;
  logic [16:0]     src_len_q;
  logic [23:0]     pat_len_q;
  logic            ovld_q, ovld_d;
  out_word_t       odata_q, odata_d;
  logic            hit_q, hit_d;
  logic            accept, rd_issue;
  dec_stat_t       dstat;
  logic [PW-1:0]   opos;
  logic [31:0]     crc;
  logic            src_rd_en;
  logic [SAW-1:0]  src_rd_addr;
  logic [7:0]      src_rd_data;
  logic            tgt_wr_en;
  logic [TAW-1:0]  tgt_wr_addr;
  logic [7:0]      tgt_wr_data;
  logic            dec_rd_en;
  logic [TAW-1:0]  dec_rd_addr;
  logic [7:0]      tgt_rd_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && !dstat.busy && (!ovld_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign rd_issue    = accept && in_data_i.func == FUNC_READ;
  assign hit_d       = 32'(in_data_i.address) < 32'(opos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= '0;
      pat_len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SOURCE_LENGTH: src_len_q <= cfg_data_i[16:0];
        REG_PATCH_LENGTH:  pat_len_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q;
    odata_d = odata_q;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (rd_issue) begin
          state_d = ST_READ;
        end else if (accept) begin
          ovld_d                = 1'b1;
          odata_d.read_byte     = '0;
          odata_d.status        = dstat.status;
          odata_d.target_length = dstat.target_length;
        end
      end
      ST_READ: begin
        state_d               = ST_IDLE;
        ovld_d                = 1'b1;
        odata_d.read_byte     = hit_q ? tgt_rd_data : 8'h00;
        odata_d.status        = dstat.status;
        odata_d.target_length = dstat.target_length;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (rd_issue) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

  bpa_source_mem #(
    .DEPTH(SOURCE_DEPTH),
    .AW   (SAW)
  ) u_source (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_en_i  (accept && in_data_i.func == FUNC_LOAD),
    .load_addr_i(in_data_i.address),
    .load_data_i(in_data_i.data_byte),
    .rd_en_i    (src_rd_en),
    .rd_addr_i  (src_rd_addr),
    .rd_data_o  (src_rd_data),
    .crc_o      (crc)
  );

  bpa_target_mem #(
    .DEPTH(TARGET_DEPTH),
    .AW   (TAW)
  ) u_target (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (tgt_wr_en),
    .wr_addr_i(tgt_wr_addr),
    .wr_data_i(tgt_wr_data),
    .rd_en_i  (dec_rd_en || rd_issue),
    .rd_addr_i(rd_issue ? TAW'(in_data_i.address) : dec_rd_addr),
    .rd_data_o(tgt_rd_data)
  );

  bpa_decoder #(
    .SOURCE_DEPTH(SOURCE_DEPTH),
    .TARGET_DEPTH(TARGET_DEPTH),
    .SAW         (SAW),
    .TAW         (TAW),
    .PW          (PW)
  ) u_decoder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pb_en_i        (accept && in_data_i.func == FUNC_PATCH),
    .pb_byte_i      (in_data_i.data_byte),
    .source_length_i(src_len_q),
    .patch_length_i (pat_len_q),
    .source_crc_i   (crc),
    .src_rd_en_o    (src_rd_en),
    .src_rd_addr_o  (src_rd_addr),
    .src_rd_data_i  (src_rd_data),
    .tgt_wr_en_o    (tgt_wr_en),
    .tgt_wr_addr_o  (tgt_wr_addr),
    .tgt_wr_data_o  (tgt_wr_data),
    .tgt_rd_en_o    (dec_rd_en),
    .tgt_rd_addr_o  (dec_rd_addr),
    .tgt_rd_data_i  (tgt_rd_data),
    .out_pos_o      (opos),
    .stat_o         (dstat)
  );

endmodule

FILE: rtl/bpa_checker.sv
// port level checks of the bps patch apply engine and their binding
`include "bps_patch_apply_engine_assert.svh"

module bpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input bpa_pkg::out_word_t             out_data_o
);
  import bpa_pkg::*;

  status_e     last_stat_q;
  logic [16:0] last_tl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stat_q <= ST_WORKING;
      last_tl_q   <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_stat_q <= out_data_o.status;
      last_tl_q   <= out_data_o.target_length;
    end
  end

  `BPA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed")

  `BPA_ASSERT(a_status_sticky, (out_valid_o && last_stat_q != ST_WORKING) |-> (out_data_o.status == last_stat_q), "status changed")

  `BPA_ASSERT(a_tlen_stable, (out_valid_o && last_tl_q != '0) |-> (out_data_o.target_length == last_tl_q), "length changed")

  `BPA_ASSERT(a_no_take_when_full, (out_valid_o && !out_ready_i) |-> !in_ready_o, "word taken while full")

endmodule

bind bps_patch_apply_engine bpa_checker u_bpa_checker (.*);
